FILE: sv/hqp_pkg.sv
// Package for the quadratic-probe hash table: widths, word types, status
// codes and the controller state type. No dependencies.
package hqp_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int KEY_W       = 32;
   localparam int MOD_W       = 11;
   localparam int LIM_W       = 8;
   localparam int ST_W        = 2;
   localparam int SLOT_W      = 10;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 11;
   localparam int DIV_BITS    = 4;
   localparam int DIV_STEPS   = KEY_W / DIV_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [MOD_W-1:0] MODULUS_RESET     = MOD_W'(1021);
   localparam logic [LIM_W-1:0] PROBE_LIMIT_RESET = LIM_W'(100);
   localparam logic [MOD_W-1:0] DEPTH_M           = MOD_W'(TABLE_DEPTH);

   localparam logic [ST_W-1:0] ST_EXISTS = 2'd0;
   localparam logic [ST_W-1:0] ST_FREE   = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

   localparam logic ACT_SEARCH = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_MODULUS     = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PROBE_LIMIT = 1'd1;

   typedef struct packed {
      logic             action;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [SLOT_W-1:0] slot_index;
   } rsp_type;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] rem;
   } mod_res_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DIV, S_RD, S_CHK, S_FIN
   } state_type;

endpackage

FILE: sv/hqp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hqp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/hqp_mod.sv
// Iterative remainder unit: key mod m, four dividend bits per cycle.
// Depends on hqp_pkg.
module hqp_mod
   import hqp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] dividend,
   input  logic [MOD_W-1:0] divisor,
   output mod_res_type      res
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [KEY_W-1:0]     num_ff, num_in;
   logic [MOD_W-1:0]     rem_ff, rem_in;
   logic                 done_ff, done_in;

   always_comb begin
      logic [MOD_W-1:0] r;
      r       = rem_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         r       = '0;
      end else if (busy_ff) begin
         // shift in one bit and reduce, remainder stays below divisor
         for (int i = 0; i < DIV_BITS; i++) begin
            r = {r[MOD_W-2:0], num_ff[KEY_W-1-i]};
            if (r >= divisor) begin
               r = r - divisor;
            end
         end
         num_in = num_ff << DIV_BITS;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign res.done = done_ff;
   assign res.rem  = rem_ff;

endmodule

FILE: sv/hash_table_quadratic_probe.sv
// Top level of the open-addressing hash table with quadratic probing.
// Depends on hqp_pkg, hqp_mod and hqp_ram.
//
//   channel | ports                         | direction | moves
//   --------+-------------------------------+-----------+--------------------
//   req     | req_valid req_ready req_data  | in        | search/insert word
//   rsp     | rsp_valid rsp_ready rsp_data  | out       | status + slot word
//   csr     | csr_we csr_addr csr_wdata     | in        | register write
//
// One word at a time: accept, then key mod modulus, then per probe a
// table memory read and then a compare, then commit; a table-full answer
// ends with a final limit check in the read state. Each probe needs its
// own read state because the memory read data is registered. After
// reset a clearing pass over every table entry zeroes the valid bits;
// req_ready stays low until it ends. A result waits in the output
// register; a finished word waits for rsp to drain before it commits.
module hash_table_quadratic_probe
   import hqp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [MOD_W-1:0] modulus_ff;
   logic [LIM_W-1:0] limit_ff;

   logic             act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [MOD_W-1:0] home_ff, home_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [MOD_W-1:0] sq_ff, sq_in;     // d*d mod m for the current d
   logic [MOD_W-1:0] inc_ff, inc_in;   // 2d+1 mod m, next step of sq
   logic [LIM_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [ST_W-1:0]  res_st_ff, res_st_in;
   logic [IDX_W-1:0] res_slot_ff, res_slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [MOD_W-1:0] m_eff;
   logic             accept, commit;
   logic             mod_start;
   mod_res_type      mod_res;

   logic             v_we, v_wdata, v_rdata;
   logic [IDX_W-1:0] v_waddr, rd_addr;
   logic             k_we;
   logic [KEY_W-1:0] k_rdata;

   // Clamp the modulus: zero acts as one, beyond depth saturates.
   always_comb begin
      if (modulus_ff == '0) begin
         m_eff = MOD_W'(1);
      end else if (modulus_ff > DEPTH_M) begin
         m_eff = DEPTH_M;
      end else begin
         m_eff = modulus_ff;
      end
   end

   function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
      logic [MOD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[MOD_W-1:0];
   endfunction

   function automatic logic [MOD_W-1:0] sub_mod(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
      logic [MOD_W:0] s;
      s = {1'b0, a} + {1'b0, m} - {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[MOD_W-1:0];
   endfunction

   assign accept = req_valid && req_ready;
   assign commit = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == IDX_W'(TABLE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_DIV;
         end
         S_DIV: begin
            if (mod_res.done) state_in = S_RD;
         end
         S_RD: begin
            state_in = (cnt_ff >= limit_ff) ? S_FIN : S_CHK;
         end
         S_CHK: begin
            if (!v_rdata || k_rdata == key_ff) state_in = S_FIN;
            else state_in = S_RD;
         end
         S_FIN: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      act_in       = act_ff;
      key_in       = key_ff;
      home_in      = home_ff;
      pos_in       = pos_ff;
      sq_in        = sq_ff;
      inc_in       = inc_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      res_st_in    = res_st_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_CLEAR: clr_in = clr_ff + 1'b1;
         S_IDLE: begin
            if (accept) begin
               act_in = req_data.action;
               key_in = req_data.key;
            end
         end
         S_DIV: begin
            if (mod_res.done) begin
               home_in = mod_res.rem;
               pos_in  = mod_res.rem[IDX_W-1:0];
               cnt_in  = '0;
               // d = 1: sq = 1 mod m, next increment 3 mod m
               if (m_eff == MOD_W'(1)) begin
                  sq_in  = '0;
                  inc_in = '0;
               end else if (m_eff == MOD_W'(2)) begin
                  sq_in  = MOD_W'(1);
                  inc_in = MOD_W'(1);
               end else begin
                  sq_in  = MOD_W'(1);
                  inc_in = MOD_W'(3);
               end
            end
         end
         S_RD: begin
            if (cnt_ff >= limit_ff) begin
               res_st_in   = ST_FULL;
               res_slot_in = '0;
            end
         end
         S_CHK: begin
            if (!v_rdata) begin
               res_st_in   = ST_FREE;
               res_slot_in = pos_ff;
            end else if (k_rdata == key_ff) begin
               res_st_in   = ST_EXISTS;
               res_slot_in = pos_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == '0 || !cnt_ff[0]) begin
                  // next probe is odd: home + d*d
                  pos_in = IDX_W'(add_mod(home_ff, sq_ff, m_eff));
               end else begin
                  // next probe is even: home - d*d, then advance d
                  pos_in = IDX_W'(sub_mod(home_ff, sq_ff, m_eff));
                  sq_in  = add_mod(sq_ff, inc_ff, m_eff);
                  inc_in = add_mod(add_mod(inc_ff, MOD_W'(1), m_eff),
                                   MOD_W'(1), m_eff);
               end
            end
         end
         S_FIN: begin
            if (commit) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = res_st_ff;
               rsp_in.slot_index = SLOT_W'(res_slot_ff);
            end
         end
         default: ;
      endcase
   end

   // Memory and handshake controls.
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      mod_start = accept;
      rd_addr   = pos_ff;
      k_we      = commit && (act_ff == ACT_INSERT) && (res_st_ff == ST_FREE);
      v_we      = k_we;
      v_waddr   = res_slot_ff;
      v_wdata   = 1'b1;
      if (state_ff == S_CLEAR) begin
         v_we    = 1'b1;
         v_waddr = clr_ff;
         v_wdata = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RESET;
         limit_ff     <= PROBE_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MODULUS:     modulus_ff <= csr_wdata[MOD_W-1:0];
               CSR_PROBE_LIMIT: limit_ff   <= csr_wdata[LIM_W-1:0];
               default: ;
            endcase
         end
      end
      act_ff      <= act_in;
      key_ff      <= key_in;
      home_ff     <= home_in;
      pos_ff      <= pos_in;
      sq_ff       <= sq_in;
      inc_ff      <= inc_in;
      cnt_ff      <= cnt_in;
      res_st_ff   <= res_st_in;
      res_slot_ff <= res_slot_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   hqp_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_data.key),
      .divisor  (m_eff),
      .res      (mod_res)
   );

   hqp_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock (clock),
      .we    (k_we),
      .waddr (res_slot_ff),
      .wdata (key_ff),
      .raddr (rd_addr),
      .rdata (k_rdata)
   );

   hqp_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid_ram (
      .clock (clock),
      .we    (v_we),
      .waddr (v_waddr),
      .wdata (v_wdata),
      .raddr (rd_addr),
      .rdata (v_rdata)
   );

endmodule
